/* rtl/lis_length_patience_search_defines.svh */
// assertion macros shared by the block
`ifndef LIS_LENGTH_PATIENCE_SEARCH_DEFINES_SVH
`define LIS_LENGTH_PATIENCE_SEARCH_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lis_pkg.sv */
package lis_pkg;

  // table depth and derived widths
  localparam int MAX_RUN = 1024;
  localparam int IDX_W   = $clog2(MAX_RUN);
  localparam int CNT_W   = $clog2(MAX_RUN + 1);
  localparam int VAL_W   = 32;
  localparam int RUN_W   = 11;

  // controller to datapath commands
  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic len_zero;
    logic search_done;
  } dp_status_t;

  // low bits of a length for the result field
  function automatic logic [RUN_W-1:0] len_to_out(input logic [CNT_W-1:0] len);
    logic [CNT_W+RUN_W-1:0] ext;
    ext = {{RUN_W{1'b0}}, len};
    return ext[RUN_W-1:0];
  endfunction

endpackage

/* rtl/lis_ram.sv */
module lis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/lis_ctrl.sv */
module lis_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lis_pkg::dp_status_t status,
  output lis_pkg::ctrl_cmd_t  cmd
);
  import lis_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // sequencing of one item: load, probe loop (skipped when the length is zero), table update
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = status.len_zero ? ST_COMMIT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (status.search_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/lis_datapath.sv */
module lis_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [lis_pkg::VAL_W-1:0] in_sample_value,
  input  logic                            in_end_of_sequence,
  input  lis_pkg::ctrl_cmd_t              cmd,
  output lis_pkg::dp_status_t             status,
  output logic [lis_pkg::RUN_W-1:0]       out_run_length,
  output logic                            out_overflowed,
  output logic                            out_final_result
);
  import lis_pkg::*;

  logic signed [VAL_W-1:0] value_r;
  logic                    last_r;
  logic [CNT_W-1:0]        lo_r, hi_r, mid_r, len_r;
  logic                    ovf_r;
  logic [RUN_W-1:0]        run_length_r;
  logic                    overflowed_r, final_r;

  logic [VAL_W-1:0]        rd_data;
  logic [IDX_W-1:0]        rd_addr;
  logic                    tail_le;
  logic [CNT_W-1:0]        lo_s, hi_s, mid_s, len_new;
  logic                    append, full, wr_en, ovf_new;

  // one probe: compare the returned tail and narrow the window
  always_comb begin
    tail_le = $signed(rd_data) <= value_r;
    lo_s    = tail_le ? mid_r + CNT_W'(1) : lo_r;
    hi_s    = tail_le ? hi_r : mid_r;
    mid_s   = lo_s + ((hi_s - lo_s) >> 1);
    rd_addr = cmd.start ? IDX_W'(len_r >> 1) : mid_s[IDX_W-1:0];
  end

  assign status.len_zero    = (len_r == '0);
  assign status.search_done = (lo_s >= hi_s);

  // table update at the found position
  always_comb begin
    append  = (lo_r == len_r);
    full    = (len_r == CNT_W'(MAX_RUN));
    wr_en   = cmd.commit && !(append && full);
    len_new = (append && !full) ? len_r + CNT_W'(1) : len_r;
    ovf_new = ovf_r | (append && full);
  end

  lis_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_RUN)
  ) u_tail_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (lo_r[IDX_W-1:0]),
    .wr_data (value_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // search window and item registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      value_r <= in_sample_value;
      last_r  <= in_end_of_sequence;
      lo_r    <= '0;
      hi_r    <= len_r;
      mid_r   <= len_r >> 1;
    end else if (cmd.step) begin
      lo_r  <= lo_s;
      hi_r  <= hi_s;
      mid_r <= mid_s;
    end
  end

  // running length and overflow flag, cleared after the last element
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.commit) begin
      len_r <= last_r ? '0 : len_new;
      ovf_r <= last_r ? 1'b0 : ovf_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      run_length_r <= len_to_out(len_new);
      overflowed_r <= ovf_new;
      final_r      <= last_r;
    end
  end

  assign out_run_length   = run_length_r;
  assign out_overflowed   = overflowed_r;
  assign out_final_result = final_r;

endmodule

/* rtl/lis_length_patience_search.sv */
// Longest non-decreasing subsequence length by patience search. Each transfer
// on the input carries one signed 32-bit element; each yields one result with
// the running length, a sticky overflow flag and the end-of-sequence marker.
// An element is handled in order: a load step, then one binary-search probe
// per cycle through the registered read port of the tail RAM (none when the
// length is zero), then a step that writes the tail and loads the result
// register. The tail table holds up to 1024 entries. Input is taken only
// between elements; a finished result waits in its output register while the
// next element is searched, and the update stalls only if that register has
// not been taken yet.
`include "lis_length_patience_search_defines.svh"

module lis_length_patience_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [lis_pkg::VAL_W-1:0] in_sample_value,
  input  logic                             in_end_of_sequence,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lis_pkg::RUN_W-1:0]        out_run_length,
  output logic                             out_overflowed,
  output logic                             out_final_result
);
  import lis_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  lis_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_sample_value    (in_sample_value),
    .in_end_of_sequence (in_end_of_sequence),
    .cmd                (cmd),
    .status             (status),
    .out_run_length     (out_run_length),
    .out_overflowed     (out_overflowed),
    .out_final_result   (out_final_result)
  );

  // checks on the sequencing
  `LIS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `LIS_ASSERT_NOW(a_start_on_transfer, cmd.start, in_valid && in_ready, "load without transfer")
  `LIS_ASSERT_NOW(a_commit_slot_free, cmd.commit, !out_valid || out_ready, "result overwritten")
  `LIS_ASSERT_NOW(a_one_command, 1'b1, $onehot0({cmd.start, cmd.step, cmd.commit}),
                  "conflicting commands")

endmodule
